// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL top level.
// No dependencies; expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (!reset && (ante)) |=> (cons)) else $error(msg);

`endif

// ===== sv/spca_pkg.sv =====
// Types and constants for the sparse pattern coefficient adjuster.
// No dependencies.
package spca_pkg;

   localparam int FUNC_W    = 2;
   localparam int PATTERN_W = 2;
   localparam int COEFF_W   = 16;
   localparam int USED_W    = 11;
   localparam int SCORE_W   = 12;
   localparam int MAG_W     = COEFF_W + 1;

   localparam int MAX_COEFFS_DEFAULT = 1024;

   localparam logic [MAG_W-1:0]   MAG_MAX       = MAG_W'(32767);
   localparam logic [SCORE_W-1:0] SCORE_STEP    = SCORE_W'(2);
   localparam logic [SCORE_W-1:0] SCORE_BIAS    = SCORE_W'(5);
   localparam logic [SCORE_W-1:0] SCORE_ACC_MAX = SCORE_W'(4090);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_SUB   = 2'd1,
      FUNC_SCORE = 2'd2,
      FUNC_PASS  = 2'd3
   } func_type;

endpackage

// ===== sv/sparse_pattern_coeff_adjust.sv =====
// Top level of the sparse pattern coefficient adjuster: one-stage datapath with
// running block counters. Depends on spca_pkg and assert_macros.svh.
//
//   channel | direction | ports                                          | handshake
//   --------+-----------+------------------------------------------------+----------
//   req     | in        | func, pattern_val, coeff_in, block_end         | valid/ready
//   rsp     | out       | coeff_out, used_count, match_score, result_last | valid/ready
//
// The adjust logic sits between the req ports and the rsp register, so a result
// appears the cycle after its req transfer.
// Throughput is one item per cycle; req_ready is low only while a result is held
// in the rsp register and rsp_ready is low.
// Reset (synchronous, active high) clears the block counters and rsp_valid.
// Counters (position, last used index, score) clear after an item with block_end.
module sparse_pattern_coeff_adjust #(
   parameter int MAX_COEFFS = spca_pkg::MAX_COEFFS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [spca_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [spca_pkg::PATTERN_W-1:0] req_pattern_val,
   input  logic signed [spca_pkg::COEFF_W-1:0] req_coeff_in,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [spca_pkg::COEFF_W-1:0] rsp_coeff_out,
   output logic [spca_pkg::USED_W-1:0]         rsp_used_count,
   output logic [spca_pkg::SCORE_W-1:0]        rsp_match_score,
   output logic                                rsp_result_last
);
   import spca_pkg::*;

   // position never exceeds MAX_COEFFS-1
   localparam int POS_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_COEFFS - 1);

   // block counters
   logic [POS_W-1:0]   position_ff,  position_in;
   logic [USED_W-1:0]  last_used_ff, last_used_in;
   logic [SCORE_W-1:0] score_acc_ff, score_acc_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COEFF_W-1:0] coeff_out_ff, coeff_out_in;
   logic [USED_W-1:0]         used_count_ff, used_count_in;
   logic [SCORE_W-1:0]        match_score_ff, match_score_in;
   logic                      result_last_ff, result_last_in;

   logic req_xfer;

   func_type              func;
   logic                  pat_nonzero;
   logic                  coeff_neg;
   logic [MAG_W-1:0]      mag;
   logic                  mag_zero;
   logic [MAG_W-1:0]      mag_up;     // magnitude plus one, saturated
   logic [MAG_W-1:0]      mag_dn;     // magnitude minus one
   logic [MAG_W-1:0]      mag_sel;
   logic signed [COEFF_W-1:0] res;
   logic [POS_W:0]        pos_inc;
   logic [SCORE_W:0]      score_sum;

   // rsp register frees up when empty or drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign func        = func_type'(req_func);
   assign pat_nonzero = (req_pattern_val != '0);
   assign coeff_neg   = req_coeff_in[COEFF_W-1];
   // -32768 yields magnitude 32768, which both add and subtract fold to 32767
   assign mag = coeff_neg ? (MAG_W'(0) - {req_coeff_in[COEFF_W-1], req_coeff_in})
                          : {1'b0, req_coeff_in};
   assign mag_zero = (mag == '0);
   assign mag_up   = (mag >= MAG_MAX) ? MAG_MAX : (mag + MAG_W'(1));
   assign mag_dn   = mag - MAG_W'(1);
   assign mag_sel  = (func == FUNC_ADD) ? mag_up : mag_dn;
   assign pos_inc  = {1'b0, position_ff} + (POS_W+1)'(1);
   assign score_sum = {1'b0, score_acc_ff} + {1'b0, SCORE_STEP};

   always_comb begin
      res          = req_coeff_in;
      last_used_in = last_used_ff;
      score_acc_in = score_acc_ff;
      case (func)
         FUNC_ADD: begin
            if (pat_nonzero) begin
               if (mag_zero) begin
                  // zero coefficient takes the pattern's sign
                  res = req_pattern_val[PATTERN_W-1] ? -COEFF_W'(1) : COEFF_W'(1);
               end else begin
                  res = coeff_neg ? -mag_sel[COEFF_W-1:0] : mag_sel[COEFF_W-1:0];
               end
            end
         end
         FUNC_SUB: begin
            if (pat_nonzero && !mag_zero) begin
               res = coeff_neg ? -mag_sel[COEFF_W-1:0] : mag_sel[COEFF_W-1:0];
            end
            if (res != '0) begin
               last_used_in = USED_W'(pos_inc);
            end
         end
         FUNC_SCORE: begin
            if (pat_nonzero && (mag == MAG_W'(1))) begin
               score_acc_in = (score_sum > {1'b0, SCORE_ACC_MAX}) ?
                              SCORE_ACC_MAX : score_sum[SCORE_W-1:0];
            end
         end
         default: begin
            // pass-through: only position advances
         end
      endcase
   end

   always_comb begin
      coeff_out_in   = res;
      used_count_in  = last_used_in;
      match_score_in = score_acc_in + SCORE_BIAS;
      result_last_in = req_block_end;
      position_in    = (position_ff < POS_LAST) ? pos_inc[POS_W-1:0] : position_ff;
      rsp_valid_in   = req_xfer || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         last_used_ff <= '0;
         score_acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            if (req_block_end) begin
               position_ff  <= '0;
               last_used_ff <= '0;
               score_acc_ff <= '0;
            end else begin
               position_ff  <= position_in;
               last_used_ff <= last_used_in;
               score_acc_ff <= score_acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         coeff_out_ff   <= coeff_out_in;
         used_count_ff  <= used_count_in;
         match_score_ff <= match_score_in;
         result_last_ff <= result_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coeff_out   = coeff_out_ff;
   assign rsp_used_count  = used_count_ff;
   assign rsp_match_score = match_score_ff;
   assign rsp_result_last = result_last_ff;

   // terms for the checks below
   logic block_end_xfer;
   logic counters_zero;
   logic keep_used;
   assign block_end_xfer = req_xfer && req_block_end;
   assign counters_zero  = (position_ff == '0) && (last_used_ff == '0) && (score_acc_ff == '0);
   assign keep_used      = req_xfer && !req_block_end && (req_func != FUNC_SUB);

`include "assert_macros.svh"

   // a block end transfer leaves every counter cleared
   `ASSERT_NEXT(a_block_end_clears, block_end_xfer, counters_zero, "counters not cleared")

   // only subtract moves the last used index within a block
   `ASSERT_NEXT(a_used_only_sub, keep_used, $stable(last_used_ff), "used index moved")

   // the running score always carries its bias
   `ASSERT_ALWAYS(a_score_bias, !rsp_valid_ff || (match_score_ff >= SCORE_BIAS), "score below bias")

   // position stays inside the block range
   `ASSERT_ALWAYS(a_pos_range, position_ff <= POS_LAST, "position beyond last index")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for sparse_pattern_coeff_adjust: directed and random coefficient streams
// checked against an in-bench predictor. Depends on spca_pkg and the RTL top level.
module testbench;
   import spca_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int BLOCK_MAX   = MAX_COEFFS_DEFAULT;

   // One adjusted coefficient as the block reports it
   typedef struct {
      logic signed [COEFF_W-1:0] coeff;
      logic [USED_W-1:0]         used;
      logic [SCORE_W-1:0]        score;
      logic                      is_last;
   } adjusted_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [FUNC_W-1:0]           req_func = FUNC_ADD;
   logic signed [PATTERN_W-1:0] req_pattern_val = '0;
   logic signed [COEFF_W-1:0]   req_coeff_in = '0;
   logic                        req_block_end = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [COEFF_W-1:0]   rsp_coeff_out;
   logic [USED_W-1:0]           rsp_used_count;
   logic [SCORE_W-1:0]          rsp_match_score;
   logic                        rsp_result_last;

   // Predictor state, mirrors the block counters
   logic [USED_W-1:0]  blk_position = '0;
   logic [USED_W-1:0]  blk_last_used = '0;
   logic [SCORE_W-1:0] blk_score_acc = '0;

   adjusted_type pending_adjust_q[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        full_rate = 1'b0;   // when set, neither side idles
   int        sink_stall = 0;

   sparse_pattern_coeff_adjust u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pattern_val (req_pattern_val),
      .req_coeff_in    (req_coeff_in),
      .req_block_end   (req_block_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coeff_out   (rsp_coeff_out),
      .rsp_used_count  (rsp_used_count),
      .rsp_match_score (rsp_match_score),
      .rsp_result_last (rsp_result_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Idle lengths: half none, most of the rest short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (full_rate || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Predicts one result and advances the block counters
   function automatic adjusted_type predict_adjust(input func_type func,
                                                input logic signed [PATTERN_W-1:0] pat,
                                                input logic signed [COEFF_W-1:0] coeff,
                                                input logic is_last);
      adjusted_type r;
      int c;
      int mag;
      int m;
      int res;
      logic neg;
      c   = int'(coeff);
      neg = c < 0;
      mag = neg ? -c : c;
      res = c;
      case (func)
         FUNC_ADD: begin
            if (pat != 0) begin
               if (mag != 0) begin
                  m = mag + 1;
                  if (m > int'(MAG_MAX)) m = int'(MAG_MAX);
                  res = neg ? -m : m;
               end else begin
                  res = (pat < 0) ? -1 : 1;
               end
            end
         end
         FUNC_SUB: begin
            // -32768 drops to magnitude 32767, never above it
            if (pat != 0 && mag != 0) begin
               m = mag - 1;
               if (m > int'(MAG_MAX)) m = int'(MAG_MAX);
               res = neg ? -m : m;
            end
            if (res != 0) blk_last_used = blk_position + 1'b1;
         end
         FUNC_SCORE: begin
            if (pat != 0 && mag == 1) begin
               blk_score_acc = blk_score_acc + SCORE_STEP;
               if (blk_score_acc > SCORE_ACC_MAX) blk_score_acc = SCORE_ACC_MAX;
            end
         end
         FUNC_PASS: ;
         default: ;
      endcase
      r.coeff   = res[COEFF_W-1:0];
      r.used    = blk_last_used;
      r.score   = blk_score_acc + SCORE_BIAS;
      r.is_last = is_last;
      if (is_last) begin
         blk_position  = '0;
         blk_last_used = '0;
         blk_score_acc = '0;
      end else if (blk_position < BLOCK_MAX - 1) begin
         blk_position = blk_position + 1'b1;
      end
      return r;
   endfunction

   // Presents one coefficient and waits for its transfer. Valid stays high
   // across back-to-back items; it only drops when a gap is taken.
   task automatic send_coeff(input func_type func, input logic signed [PATTERN_W-1:0] pat,
                             input logic signed [COEFF_W-1:0] coeff, input logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_pattern_val <= pat;
      req_coeff_in    <= coeff;
      req_block_end   <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_adjust_q.push_back(predict_adjust(func, pat, coeff, is_last));
   endtask

   // Add: growth, sign from pattern on zero, zero pattern, pattern -2, saturation, -32768
   task automatic test_add_extremes();
      send_coeff(FUNC_ADD, 2'sd1, 16'sd0, 1'b0);
      send_coeff(FUNC_ADD, -2'sd1, 16'sd0, 1'b0);
      send_coeff(FUNC_ADD, -2'sd2, 16'sd0, 1'b0);
      send_coeff(FUNC_ADD, 2'sd0, 16'sd0, 1'b0);
      send_coeff(FUNC_ADD, 2'sd0, 16'sd5, 1'b0);
      send_coeff(FUNC_ADD, 2'sd1, 16'sd32767, 1'b0);
      send_coeff(FUNC_ADD, -2'sd1, -16'sd32767, 1'b0);
      send_coeff(FUNC_ADD, 2'sd1, -16'sd32768, 1'b0);
      send_coeff(FUNC_ADD, -2'sd2, 16'sd7, 1'b1);
   endtask

   // Subtract: zeroing, shrink, used index tracking, other modes in between
   task automatic test_subtract_tracking();
      send_coeff(FUNC_SUB, 2'sd1, 16'sd1, 1'b0);
      send_coeff(FUNC_SUB, -2'sd1, -16'sd1, 1'b0);
      send_coeff(FUNC_SUB, 2'sd0, 16'sd7, 1'b0);
      send_coeff(FUNC_SUB, 2'sd1, 16'sd0, 1'b0);
      send_coeff(FUNC_SUB, 2'sd1, -16'sd32768, 1'b0);
      send_coeff(FUNC_SUB, -2'sd2, 16'sd32767, 1'b0);
      send_coeff(FUNC_ADD, 2'sd1, 16'sd3, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd1, 16'sd1, 1'b0);
      send_coeff(FUNC_PASS, 2'sd1, -16'sd12345, 1'b0);
      send_coeff(FUNC_SUB, 2'sd1, 16'sd1, 1'b1);
   endtask

   // Score: hits on magnitude one only, -32768 counts as large
   task automatic test_score_hits();
      send_coeff(FUNC_SCORE, 2'sd1, 16'sd1, 1'b0);
      send_coeff(FUNC_SCORE, -2'sd1, -16'sd1, 1'b0);
      send_coeff(FUNC_SCORE, -2'sd2, 16'sd1, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd0, 16'sd1, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd1, 16'sd2, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd1, 16'sd0, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd1, -16'sd32768, 1'b0);
      send_coeff(FUNC_SUB, 2'sd1, 16'sd4, 1'b1);
   endtask

   // Long block of unit hits, back to back on both sides, then mixed modes
   task automatic test_long_block();
      full_rate = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_coeff(FUNC_SCORE, (i % 2) ? -2'sd1 : 2'sd1, (i % 3) ? -16'sd1 : 16'sd1, 1'b0);
      end
      full_rate = 1'b0;
      send_coeff(FUNC_SUB, 2'sd0, 16'sd3, 1'b0);
      send_coeff(FUNC_ADD, 2'sd1, 16'sd3, 1'b0);
      send_coeff(FUNC_SCORE, 2'sd1, 16'sd1, 1'b1);
   endtask

   // Random blocks, one mode per block with some mixed-in noise
   task automatic test_random_blocks(input int n_items);
      int sent;
      int len;
      int r;
      func_type mode;
      func_type func;
      logic signed [PATTERN_W-1:0] pat;
      logic signed [COEFF_W-1:0] coeff;
      logic is_last;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 80) len = $urandom_range(1, 24);
         else if (r < 95) len = $urandom_range(25, 80);
         else len = $urandom_range(81, 200);
         mode = func_type'($urandom_range(0, 2));
         for (int i = 0; i < len; i++) begin
            full_rate = (sent >= 250 && sent < 350);
            func = ($urandom_range(0, 99) < 8) ? func_type'($urandom_range(0, 3)) : mode;
            r = $urandom_range(0, 99);
            if (r < 30) pat = 2'sd0;
            else if (r < 63) pat = 2'sd1;
            else if (r < 96) pat = -2'sd1;
            else pat = -2'sd2;
            r = $urandom_range(0, 99);
            if (r < 60) coeff = COEFF_W'(int'($urandom_range(0, 6)) - 3);
            else if (r < 85) coeff = COEFF_W'($urandom);
            else if (r < 95) begin
               case ($urandom_range(0, 4))
                  0: coeff = 16'sd32767;
                  1: coeff = -16'sd32767;
                  2: coeff = -16'sd32768;
                  3: coeff = 16'sd32766;
                  default: coeff = -16'sd32766;
               endcase
            end else coeff = 16'sd0;
            // occasional early end breaks a block short
            is_last = (i == len - 1) || ($urandom_range(0, 99) < 3);
            send_coeff(func, pat, coeff, is_last);
            sent++;
            if (is_last) break;
         end
      end
      full_rate = 1'b0;
   endtask

   // Result sink: ready with random stalls, none started while full_rate is set
   always @(posedge clock) begin
      if (sink_stall > 0) begin
         rsp_ready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (!full_rate && $urandom_range(0, 99) < 25) sink_stall = pick_gap();
      end
   end

   // Result check against the oldest pending prediction
   always @(posedge clock) begin : check_rsp
      adjusted_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_adjust_q.size() == 0) begin
            $error("result transfer with no prediction pending");
            error_count++;
         end else begin
            want = pending_adjust_q.pop_front();
            if (rsp_coeff_out !== want.coeff) begin
               $error("coeff_out: expected %0d, actual %0d", want.coeff, rsp_coeff_out);
               error_count++;
            end
            if (rsp_used_count !== want.used) begin
               $error("used_count: expected %0d, actual %0d", want.used, rsp_used_count);
               error_count++;
            end
            if (rsp_match_score !== want.score) begin
               $error("match_score: expected %0d, actual %0d", want.score, rsp_match_score);
               error_count++;
            end
            if (rsp_result_last !== want.is_last) begin
               $error("result_last: expected %0d, actual %0d", want.is_last, rsp_result_last);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_add_extremes();
      test_subtract_tracking();
      test_score_hits();
      test_long_block();
      test_random_blocks(480);
      req_valid <= 1'b0;
      // drain, then wait for any stray result
      while (pending_adjust_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/spca_pkg.sv
sv/sparse_pattern_coeff_adjust.sv
tb/sv/testbench.sv
